@@ hdl/c2r_pkg.sv @@
// Shared types, widths and register indices for the streaming 3x3 convolution.
// No dependencies; imported by conv2d_relu_stream and its testbench.
`default_nettype none

package c2r_pkg;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 11;
  localparam int STR_W  = 4;
  localparam int CFG_W  = 48;
  localparam int IDX_W  = 3;
  localparam int VAL_W  = 27;
  localparam int OCOL_W = 10;
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int ACC_W  = PROD_W + 4;
  localparam int TAPS   = 9;

  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [CFG_W-1:0]          coef_row_t;

  // Register indices on the configuration port
  localparam logic [IDX_W-1:0] CFG_COEF_TOP = 3'd0;
  localparam logic [IDX_W-1:0] CFG_COEF_MID = 3'd1;
  localparam logic [IDX_W-1:0] CFG_COEF_BOT = 3'd2;
  localparam logic [IDX_W-1:0] CFG_WIDTH    = 3'd3;
  localparam logic [IDX_W-1:0] CFG_HEIGHT   = 3'd4;
  localparam logic [IDX_W-1:0] CFG_STRIDE   = 3'd5;

  // Pick one signed coefficient out of a packed kernel row, leftmost in low bits
  function automatic coef_t coef_at(input coef_row_t row_bits, input logic [1:0] col);
    return coef_t'(row_bits[COEF_W*col +: COEF_W]);
  endfunction

endpackage

`default_nettype wire

@@ hdl/conv2d_relu_stream.sv @@
// Streaming 3x3 convolution with ReLU and stride over a raster pixel stream.
// Depends on c2r_pkg (types, widths, register indices).
`default_nettype none

// Channel  | ports                                              | direction
// ---------+----------------------------------------------------+----------
// input    | in_valid, in_stall, in_pixel, in_start_of_frame    | sink
// result   | out_valid, out_stall, out_conv_value, out_row,     | source
//          | out_col, out_frame_done                            |
// config   | cfg_we, cfg_index, cfg_data                        | sink
//
// One pixel is taken every cycle unless the input stalls; a result passes the
// line store read, window, products and summing output register in turn.
// Writing stride starts a serial division that re-derives the strided row and
// column positions; the input stalls while it runs.
// Reset (rst_n low, synchronous) clears counters, window, valid flags and
// configuration; the line store and data registers hold no reset value. A
// stalled output backs up through the stages only once they are all full.

module conv2d_relu_stream
  import c2r_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [PIX_W-1:0]       in_pixel,
  input  wire                    in_start_of_frame,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [VAL_W-1:0]       out_conv_value,
  output logic [ROW_W-1:0]       out_row,
  output logic [OCOL_W-1:0]      out_col,
  output logic                   out_frame_done,
  input  wire                    cfg_we,
  input  wire  [IDX_W-1:0]       cfg_index,
  input  wire  [CFG_W-1:0]       cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = 13;
  localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);
  localparam int DIV_STEPS = ROW_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  coef_row_t          coef_row_r [3];
  logic [COL_W-1:0]   width_r;
  logic [ROW_W-1:0]   height_r;
  logic [STR_W-1:0]   stride_r;

  logic               stride_wr;
  assign stride_wr = cfg_we && (cfg_index == CFG_STRIDE);

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_row_r[0] <= '0;
      coef_row_r[1] <= '0;
      coef_row_r[2] <= '0;
      width_r       <= 11'd1024;
      height_r      <= 12'd1024;
      stride_r      <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COEF_TOP: coef_row_r[0] <= cfg_data;
        CFG_COEF_MID: coef_row_r[1] <= cfg_data;
        CFG_COEF_BOT: coef_row_r[2] <= cfg_data;
        CFG_WIDTH:    width_r       <= cfg_data[COL_W-1:0];
        CFG_HEIGHT:   height_r      <= cfg_data[ROW_W-1:0];
        CFG_STRIDE:   stride_r      <= cfg_data[STR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame geometry to its legal range
  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [STR_W-1:0] s_eff;

  always_comb begin
    w_eff = WW'(width_r);
    if (w_eff < 13'd3) begin
      w_eff = 13'd3;
    end
    if (w_eff > MAXW) begin
      w_eff = MAXW;
    end
    h_eff = (height_r < 12'd3) ? 12'd3 : height_r;
    s_eff = (stride_r == '0) ? 4'd1 : stride_r;
  end

  // ---------------------------------------------------------------------
  // Position counters with strided phase and quotient
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [STR_W-1:0] rp_r, rp_nxt, cp_r, cp_nxt;
  logic [ROW_W-1:0] rq_r, rq_nxt;
  logic [COL_W-1:0] cq_r, cq_nxt;

  logic             in_acc;
  logic [ROW_W-1:0] r_cur;
  logic [COL_W-1:0] c_cur;
  logic [STR_W-1:0] rp_cur, cp_cur;
  logic [ROW_W-1:0] rq_cur;
  logic [COL_W-1:0] cq_cur;
  logic [ROW_W-1:0] tr;
  logic [COL_W-1:0] lc;
  logic             gen;
  logic             last;
  logic             col_wrap, row_wrap;
  logic [AW-1:0]    raddr;

  always_comb begin
    // A frame start restarts both counters on this pixel
    r_cur  = in_start_of_frame ? '0 : row_r;
    c_cur  = in_start_of_frame ? '0 : col_r;
    rp_cur = in_start_of_frame ? '0 : rp_r;
    cp_cur = in_start_of_frame ? '0 : cp_r;
    rq_cur = in_start_of_frame ? '0 : rq_r;
    cq_cur = in_start_of_frame ? '0 : cq_r;
    raddr  = AW'(c_cur);

    tr   = r_cur - 12'd2;
    lc   = c_cur - 11'd2;
    gen  = (r_cur >= 12'd2) && (c_cur >= 11'd2) && (rp_cur == '0) && (cp_cur == '0);
    last = ((WW'(tr) + WW'(s_eff)) > (WW'(h_eff) - 13'd3)) &&
           ((WW'(lc) + WW'(s_eff)) > (w_eff - 13'd3));

    col_wrap = (WW'(c_cur) + 13'd1) >= w_eff;
    row_wrap = (WW'(r_cur) + 13'd1) >= WW'(h_eff);

    row_nxt = r_cur;
    rp_nxt  = rp_cur;
    rq_nxt  = rq_cur;
    if (col_wrap) begin
      col_nxt = '0;
      cp_nxt  = '0;
      cq_nxt  = '0;
      if (row_wrap) begin
        row_nxt = '0;
        rp_nxt  = '0;
        rq_nxt  = '0;
      end else begin
        row_nxt = r_cur + 12'd1;
        if (r_cur < 12'd2) begin
          rp_nxt = '0;
          rq_nxt = '0;
        end else if (rp_cur == s_eff - 4'd1) begin
          rp_nxt = '0;
          rq_nxt = rq_cur + 12'd1;
        end else begin
          rp_nxt = rp_cur + 4'd1;
        end
      end
    end else begin
      col_nxt = c_cur + 11'd1;
      cq_nxt  = cq_cur;
      if (c_cur < 11'd2) begin
        cp_nxt = '0;
        cq_nxt = '0;
      end else if (cp_cur == s_eff - 4'd1) begin
        cp_nxt = '0;
        cq_nxt = cq_cur + 11'd1;
      end else begin
        cp_nxt = cp_cur + 4'd1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Serial divider: re-derive phase and quotient after a stride write
  // ---------------------------------------------------------------------
  logic                 div_busy_r;
  logic [3:0]           div_cnt_r;
  logic [STR_W-1:0]     div_s_r;
  logic [ROW_W-1:0]     div_rd_r, div_rd_nxt;
  logic [ROW_W-1:0]     div_cd_r, div_cd_nxt;
  logic [STR_W-1:0]     div_rr_r, div_rr_nxt;
  logic [STR_W-1:0]     div_cr_r, div_cr_nxt;
  logic [STR_W:0]       div_rt, div_ct;
  logic                 div_rge, div_cge;
  logic                 div_last;

  // One quotient bit per cycle for both row and column
  always_comb begin
    div_rt     = {div_rr_r, div_rd_r[ROW_W-1]};
    div_ct     = {div_cr_r, div_cd_r[ROW_W-1]};
    div_rge    = div_rt >= {1'b0, div_s_r};
    div_cge    = div_ct >= {1'b0, div_s_r};
    div_rr_nxt = div_rge ? STR_W'(div_rt - {1'b0, div_s_r}) : STR_W'(div_rt);
    div_cr_nxt = div_cge ? STR_W'(div_ct - {1'b0, div_s_r}) : STR_W'(div_ct);
    div_rd_nxt = {div_rd_r[ROW_W-2:0], div_rge};
    div_cd_nxt = {div_cd_r[ROW_W-2:0], div_cge};
    div_last   = div_cnt_r == 4'(DIV_STEPS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
      div_s_r    <= 4'd1;
      div_rd_r   <= '0;
      div_cd_r   <= '0;
      div_rr_r   <= '0;
      div_cr_r   <= '0;
    end else if (stride_wr) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
      div_s_r    <= (cfg_data[STR_W-1:0] == '0) ? 4'd1 : cfg_data[STR_W-1:0];
      div_rd_r   <= (row_r >= 12'd2) ? row_r - 12'd2 : '0;
      div_cd_r   <= (col_r >= 11'd2) ? ROW_W'(col_r - 11'd2) : '0;
      div_rr_r   <= '0;
      div_cr_r   <= '0;
    end else if (div_busy_r) begin
      div_cnt_r  <= div_cnt_r + 4'd1;
      div_rd_r   <= div_rd_nxt;
      div_cd_r   <= div_cd_nxt;
      div_rr_r   <= div_rr_nxt;
      div_cr_r   <= div_cr_nxt;
      if (div_last) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  // Advance counters on each item, load divider results when done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      rp_r  <= '0;
      cp_r  <= '0;
      rq_r  <= '0;
      cq_r  <= '0;
    end else if (div_busy_r && div_last && !stride_wr) begin
      rp_r <= div_rr_nxt;
      cp_r <= div_cr_nxt;
      rq_r <= div_rd_nxt;
      cq_r <= COL_W'(div_cd_nxt);
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      rp_r  <= rp_nxt;
      cp_r  <= cp_nxt;
      rq_r  <= rq_nxt;
      cq_r  <= cq_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and stage advance
  // ---------------------------------------------------------------------
  logic s0_v_r, s1_v_r, s2_v_r;
  logic s0_adv, s1_adv, s2_adv;

  always_comb begin
    s2_adv   = s2_v_r && (!out_valid || !out_stall);
    s1_adv   = s1_v_r && (!s2_v_r || s2_adv);
    s0_adv   = s0_v_r && (!s1_v_r || s1_adv);
    in_stall = div_busy_r || (s0_v_r && !s0_adv);
    in_acc   = in_valid && !in_stall;
  end

  // ---------------------------------------------------------------------
  // Stage 0: line store read, item held with its output position
  // ---------------------------------------------------------------------
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r;
  logic [2*PIX_W-1:0] byp_d_r;
  logic               byp_r;
  logic [2*PIX_W-1:0] rd_eff;
  logic [2*PIX_W-1:0] wdata;
  pix_t               s0_px_r;
  logic               s0_gen_r;
  logic               s0_last_r;
  logic [ROW_W-1:0]   s0_row_r;
  logic [OCOL_W-1:0]  s0_col_r;
  logic [AW-1:0]      s0_addr_r;
  pix_t               top_px, mid_px;

  // Line store word: high byte two rows up, low byte one row up
  always_comb begin
    rd_eff = byp_r ? byp_d_r : rd_r;
    top_px = rd_eff[2*PIX_W-1:PIX_W];
    mid_px = rd_eff[PIX_W-1:0];
    wdata  = {mid_px, s0_px_r};
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      line_mem[s0_addr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= line_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_acc) begin
      s0_v_r <= 1'b1;
    end else if (s0_adv) begin
      s0_v_r <= 1'b0;
    end
  end

  // Capture the item; forward a same-address write landing on this edge
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_px_r   <= in_pixel;
      s0_gen_r  <= gen;
      s0_last_r <= last;
      s0_row_r  <= rq_cur;
      s0_col_r  <= OCOL_W'(cq_cur);
      s0_addr_r <= raddr;
      byp_r     <= s0_adv && (s0_addr_r == raddr);
      byp_d_r   <= wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: 3x3 window, shifted left on every item
  // ---------------------------------------------------------------------
  pix_t              win_r [TAPS];
  logic              s1_last_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [OCOL_W-1:0] s1_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAPS; k++) begin
        win_r[k] <= '0;
      end
    end else if (s0_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i*3]     <= win_r[i*3 + 1];
        win_r[i*3 + 1] <= win_r[i*3 + 2];
      end
      win_r[2] <= top_px;
      win_r[5] <= mid_px;
      win_r[8] <= s0_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s0_adv) begin
      s1_v_r <= s0_gen_r;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s1_last_r <= s0_last_r;
      s1_row_r  <= s0_row_r;
      s1_col_r  <= s0_col_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: nine parallel products
  // ---------------------------------------------------------------------
  prod_t             prod_r [TAPS];
  prod_t             prod_nxt [TAPS];
  logic              s2_last_r;
  logic [ROW_W-1:0]  s2_row_r;
  logic [OCOL_W-1:0] s2_col_r;

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      prod_nxt[k] = $signed({1'b0, win_r[k]}) * coef_at(coef_row_r[k/3], 2'(k%3));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_adv) begin
      s2_v_r <= 1'b1;
    end else if (s2_adv) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int k = 0; k < TAPS; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      s2_last_r <= s1_last_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: sum, clamp negatives to zero
  // ---------------------------------------------------------------------
  acc_t             acc;
  logic [VAL_W-1:0] relu;

  always_comb begin
    acc = '0;
    for (int k = 0; k < TAPS; k++) begin
      acc = acc + ACC_W'(prod_r[k]);
    end
    relu = acc[ACC_W-1] ? '0 : acc[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_conv_value <= relu;
      out_row        <= s2_row_r;
      out_col        <= s2_col_r;
      out_frame_done <= s2_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Window must not shift under a product stage still waiting
  a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s0_adv |-> (!s1_v_r || s1_adv))
    else $error("window shifted while stage 1 was stalled");

  // Strided phases stay below the stride outside a re-division
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !div_busy_r |-> ((rp_r < s_eff) && (cp_r < s_eff)))
    else $error("strided phase out of range");

  // No item is taken while the divider rewrites the counters
  a_div_block: assert property (@(posedge clk) disable iff (!rst_n)
    $past(div_busy_r) && div_busy_r |-> !in_acc)
    else $error("item taken during stride re-division");

  // A new result only appears after a product stage hand-over
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s2_v_r))
    else $error("result appeared without a source item");

endmodule

`default_nettype wire

@@ test/conv2d_relu_stream_test.sv @@
// Self-checking testbench for conv2d_relu_stream: directed table, frame shrink, then random frames.
// Depends on c2r_pkg (widths, register indices) and the conv2d_relu_stream RTL.

module conv2d_relu_stream_test
  import c2r_pkg::*;
;

  localparam int MAX_W         = 1024;
  localparam int SETTLE_CYCLES = 16;   // pipeline depth plus the stride division
  localparam int RANDOM_ITEMS  = 400;
  localparam int N_DIR         = 21;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              done;
  } conv_result_t;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
    pix_t             pixel;
    logic             sof;
    logic [3:0]       count;
    logic             lit;
    conv_result_t     res;
  } dir_row_t;

  typedef enum {FRAME_FULL, FRAME_CUT, FRAME_NOISY} frame_kind_e;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  pix_t               in_pixel;
  logic               in_start_of_frame;
  logic               out_valid;
  logic               out_stall;
  logic [VAL_W-1:0]   out_conv_value;
  logic [ROW_W-1:0]   out_row;
  logic [OCOL_W-1:0]  out_col;
  logic               out_frame_done;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  conv2d_relu_stream uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .in_start_of_frame (in_start_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_conv_value    (out_conv_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_frame_done    (out_frame_done),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the block: registers, line stores, window and raster counters
  logic [CFG_W-1:0]  k_top, k_mid, k_bot;
  logic [COL_W-1:0]  img_w;
  logic [ROW_W-1:0]  img_h;
  logic [STR_W-1:0]  step_sz;
  pix_t              line_mem [2*MAX_W];
  pix_t              win [3][3];
  logic [ROW_W-1:0]  row_cnt;
  logic [OCOL_W-1:0] col_cnt;

  conv_result_t expected_results [$];
  int           mismatches = 0;
  int           items_sent = 0;
  bit           no_gaps = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic int eff_width();
    int w;
    w = img_w;
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = img_h;
    if (h < 3) h = 3;
    return h;
  endfunction

  function automatic int eff_stride();
    return (step_sz == 0) ? 1 : int'(step_sz);
  endfunction

  // Shift one pixel through the line stores and window; work out the strided result
  task automatic convolve_pixel(input pix_t pix, input logic sof, output bit hit,
                                output conv_result_t res);
    int w, h, s, r, c, tr, lc, acc, px_i, k_i;
    pix_t top_px, mid_px;
    logic [CFG_W-1:0] krow;
    logic signed [COEF_W-1:0] k;
    w = eff_width();
    h = eff_height();
    s = eff_stride();
    if (sof) begin
      row_cnt = '0;
      col_cnt = '0;
    end
    r = row_cnt;
    c = col_cnt;
    top_px = line_mem[MAX_W + c];
    mid_px = line_mem[c];
    line_mem[MAX_W + c] = mid_px;
    line_mem[c] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top_px;
    win[1][2] = mid_px;
    win[2][2] = pix;
    hit = 1'b0;
    res = '0;
    if (r >= 2 && c >= 2) begin
      tr = r - 2;
      lc = c - 2;
      if (tr % s == 0 && lc % s == 0) begin
        acc = 0;
        for (int i = 0; i < 3; i++) begin
          krow = (i == 0) ? k_top : (i == 1) ? k_mid : k_bot;
          for (int j = 0; j < 3; j++) begin
            k = krow[COEF_W*j +: COEF_W];
            px_i = win[i][j];
            k_i = k;
            acc += px_i * k_i;
          end
        end
        // ReLU
        if (acc < 0) acc = 0;
        res.value = acc[VAL_W-1:0];
        res.row = ROW_W'(tr / s);
        res.col = OCOL_W'(lc / s);
        res.done = (tr + s > h - 3) && (lc + s > w - 3);
        hit = 1'b1;
      end
    end
    // Advance the raster position, wrapping at the end of the row and frame
    if (c + 1 >= w) begin
      col_cnt = '0;
      row_cnt = (r + 1 >= h) ? '0 : ROW_W'(r + 1);
    end else begin
      col_cnt = OCOL_W'(c + 1);
    end
  endtask

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic pix_t rand_pixel();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return pix_t'($urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_W-1:0] rand_kernel_row();
    logic [CFG_W-1:0] bits;
    int sel;
    bits = '0;
    for (int j = 0; j < 3; j++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       bits[COEF_W*j +: COEF_W] = 16'h7FFF;
        1:       bits[COEF_W*j +: COEF_W] = 16'h8000;
        2:       bits[COEF_W*j +: COEF_W] = 16'h0000;
        default: bits[COEF_W*j +: COEF_W] = COEF_W'($urandom);
      endcase
    end
    return bits;
  endfunction

  // Write one register and track it in the mirror
  task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    case (index)
      CFG_COEF_TOP: k_top = data;
      CFG_COEF_MID: k_mid = data;
      CFG_COEF_BOT: k_bot = data;
      CFG_WIDTH:    img_w = data[COL_W-1:0];
      CFG_HEIGHT:   img_h = data[ROW_W-1:0];
      CFG_STRIDE:   step_sz = data[STR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stride goes last, since its write kicks off the division
  task automatic set_shape(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [CFG_W-1:0] s);
    write_reg(CFG_COEF_TOP, rand_kernel_row());
    write_reg(CFG_COEF_MID, rand_kernel_row());
    write_reg(CFG_COEF_BOT, rand_kernel_row());
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_STRIDE, s);
  endtask

  // Hold the sender off until every pending result has arrived
  task automatic drain(input bit settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_pixel(input pix_t pix, input logic sof, input bit lit = 1'b0,
                            input conv_result_t lit_res = '0);
    int gap;
    bit hit;
    conv_result_t res;
    gap = no_gaps ? 0 : gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_pixel          <= pix;
    in_start_of_frame <= sof;
    do @(posedge clk); while (in_stall);
    items_sent++;
    convolve_pixel(pix, sof, hit, res);
    if (lit) expected_results.push_back(lit_res);
    else if (hit) expected_results.push_back(res);
  endtask

  task automatic send_frame(input frame_kind_e kind);
    int n, len;
    logic sof;
    n = eff_width() * eff_height();
    len = (kind == FRAME_CUT) ? $urandom_range(1, n - 1) : n;
    for (int i = 0; i < len; i++) begin
      // Let a frame run on from a wrapped counter now and then
      if (i == 0) sof = !(row_cnt == 0 && col_cnt == 0 && $urandom_range(0, 2) == 0);
      else sof = (kind == FRAME_NOISY) && ($urandom_range(0, 29) == 0);
      if ($urandom_range(0, 199) == 0) drain(1'b0);
      send_pixel(rand_pixel(), sof);
    end
  endtask

  function automatic dir_row_t cfg_row(input logic [IDX_W-1:0] index,
                                       input logic [CFG_W-1:0] data);
    dir_row_t row_v;
    row_v = '0;
    row_v.kind = ROW_CFG;
    row_v.index = index;
    row_v.data = data;
    return row_v;
  endfunction

  function automatic dir_row_t pix_row(input pix_t pixel, input logic sof,
                                       input logic [3:0] count);
    dir_row_t row_v;
    row_v = '0;
    row_v.kind = ROW_PIX;
    row_v.pixel = pixel;
    row_v.sof = sof;
    row_v.count = count;
    return row_v;
  endfunction

  function automatic dir_row_t lit_row(input pix_t pixel, input logic sof,
                                       input logic [VAL_W-1:0] value,
                                       input logic [ROW_W-1:0] row,
                                       input logic [OCOL_W-1:0] col, input logic done);
    dir_row_t row_v;
    row_v = pix_row(pixel, sof, 4'd1);
    row_v.lit = 1'b1;
    row_v.res = '{value: value, row: row, col: col, done: done};
    return row_v;
  endfunction

  dir_row_t dir_rows [N_DIR];

  // Result side: compare each taken item with the oldest expectation
  always @(posedge clk) begin
    conv_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_conv_value, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_conv_value !== want.value)
          report_mismatch("conv_value", out_conv_value, want.value);
        if (out_row !== want.row) report_mismatch("out_row", out_row, want.row);
        if (out_col !== want.col) report_mismatch("out_col", out_col, want.col);
        if (out_frame_done !== want.done)
          report_mismatch("frame_done", out_frame_done, want.done);
      end
    end
  end

  // Result side back-pressure: mostly short stalls, occasional long free runs
  initial begin
    int run_len;
    out_stall = 1'b0;
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
      repeat (run_len) @(negedge clk) out_stall <= 1'b0;
      repeat (gap_len()) @(negedge clk) out_stall <= 1'b1;
    end
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int base;
    bit cfg_pending;
    int wait_cycles;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_pixel          = '0;
    in_start_of_frame = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    k_top   = '0;
    k_mid   = '0;
    k_bot   = '0;
    img_w   = COL_W'(1024);
    img_h   = ROW_W'(1024);
    step_sz = STR_W'(1);
    row_cnt = '0;
    col_cnt = '0;
    foreach (line_mem[n]) line_mem[n] = '0;
    foreach (win[i, j]) win[i][j] = '0;

    // Full-scale kernel on a white frame, then a corner-pick kernel with
    // out-of-range geometry, then a frame that follows on without a start
    dir_rows = '{
      cfg_row(CFG_COEF_TOP, 48'h7FFF_7FFF_7FFF),
      cfg_row(CFG_COEF_MID, 48'h7FFF_7FFF_7FFF),
      cfg_row(CFG_COEF_BOT, 48'h7FFF_7FFF_7FFF),
      cfg_row(CFG_WIDTH, 48'd3),
      cfg_row(CFG_HEIGHT, 48'd3),
      cfg_row(CFG_STRIDE, 48'd1),
      pix_row(8'hFF, 1'b1, 4'd1),
      pix_row(8'hFF, 1'b0, 4'd7),
      lit_row(8'hFF, 1'b0, 27'd75200265, 12'd0, 10'd0, 1'b1),
      cfg_row(CFG_COEF_TOP, 48'h0000_0000_0001),
      cfg_row(CFG_COEF_MID, 48'h0),
      cfg_row(CFG_COEF_BOT, 48'h0),
      cfg_row(CFG_WIDTH, 48'd2),
      cfg_row(CFG_HEIGHT, 48'd0),
      cfg_row(CFG_STRIDE, 48'd0),
      pix_row(8'h5A, 1'b1, 4'd1),
      pix_row(8'hFF, 1'b0, 4'd7),
      lit_row(8'hFF, 1'b0, 27'h5A, 12'd0, 10'd0, 1'b1),
      pix_row(8'h00, 1'b0, 4'd1),
      pix_row(8'h80, 1'b0, 4'd7),
      lit_row(8'hFF, 1'b0, 27'd0, 12'd0, 10'd0, 1'b1)
    };

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    cfg_pending = 1'b0;
    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_CFG) begin
        if (cfg_pending) drain(1'b1);
        cfg_pending = 1'b0;
        write_reg(dir_rows[n].index, dir_rows[n].data);
      end else begin
        cfg_pending = 1'b1;
        repeat (dir_rows[n].count)
          send_pixel(dir_rows[n].pixel, dir_rows[n].sof, dir_rows[n].lit, dir_rows[n].res);
      end
    end
    drain(1'b1);

    // Shrink the frame under running counters: stop at row 5, column 6 of 8x8
    set_shape(8, 8, 1);
    for (int i = 0; i < 46; i++) send_pixel(rand_pixel(), i == 0);
    drain(1'b1);
    write_reg(CFG_WIDTH, 4);
    write_reg(CFG_HEIGHT, 4);
    for (int i = 0; i < 33; i++) send_pixel(rand_pixel(), 1'b0);
    drain(1'b1);

    // Random phases of small frames
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      set_shape(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9),
                ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(0, 15));
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0, 1:    send_frame(FRAME_CUT);
          2, 3:    send_frame(FRAME_NOISY);
          default: send_frame(FRAME_FULL);
        endcase
      end
      drain(1'b1);
    end

    // Let the tail drain, bounded
    @(negedge clk);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never produced", 0, expected_results.size());

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
